// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the resonator bank checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- rtl/mrb_pkg.sv -----
// ----------------------------------------------------------------------------
// mrb_pkg
// Widths, codes and control structs for the modal resonator bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mrb_pkg;

  // bank size
  localparam int MAX_MODES = 64;
  localparam int MODE_W    = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int CNT_W     = $clog2(MAX_MODES + 1);

  // field widths
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 6;
  localparam int COEF_W    = 32;
  localparam int SAMP_W    = 24;
  localparam int ST_W      = 40;
  localparam int ACTIVE_W  = 7;
  localparam int ACC_W     = ST_W + CNT_W;

  // func codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MODES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN  = 1'd1;
  localparam logic [COEF_W-1:0]    GAIN_RESET       = 32'h4000_0000;

  // controller to datapath
  typedef struct packed {
    logic              start;   // new sample: clear sum, latch force
    logic              load;    // write one mode's coefficients
    logic              clear;   // drop all delay states
    logic              issue;   // launch one mode into the pipeline
    logic [MODE_W-1:0] mode;
    logic              finish;  // move the sum into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/mrb_req_if.sv -----
// ----------------------------------------------------------------------------
// mrb_req_if
// Input channel: one command item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrb_req_if;
  logic                                valid;
  logic                                ready;
  logic        [mrb_pkg::FUNC_W-1:0]   func;
  logic        [mrb_pkg::IDX_W-1:0]    mode_index;
  logic signed [mrb_pkg::COEF_W-1:0]   coef_feedback_one;
  logic signed [mrb_pkg::COEF_W-1:0]   coef_feedback_two;
  logic signed [mrb_pkg::COEF_W-1:0]   coef_drive;
  logic signed [mrb_pkg::COEF_W-1:0]   coef_pickup;
  logic signed [mrb_pkg::SAMP_W-1:0]   force_sample;

  modport source (
    output valid, func, mode_index, coef_feedback_one, coef_feedback_two,
           coef_drive, coef_pickup, force_sample,
    input  ready
  );

  modport sink (
    input  valid, func, mode_index, coef_feedback_one, coef_feedback_two,
           coef_drive, coef_pickup, force_sample,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/mrb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mrb_rsp_if
// Output channel: one output sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrb_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [mrb_pkg::SAMP_W-1:0] out_sample;
  logic                              saturated;

  modport source (output valid, out_sample, saturated, input ready);
  modport sink   (input valid, out_sample, saturated, output ready);
endinterface

`default_nettype wire

// ----- rtl/mrb_regs.sv -----
// ----------------------------------------------------------------------------
// mrb_regs
// Configuration registers: active mode count and output gain.
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [mrb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mrb_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic      [mrb_pkg::ACTIVE_W-1:0]      active_modes,
  output logic signed [mrb_pkg::COEF_W-1:0]      output_gain
);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_modes <= '0;
      output_gain  <= mrb_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mrb_pkg::REG_ACTIVE_MODES: active_modes <= cfg_data[mrb_pkg::ACTIVE_W-1:0];
        mrb_pkg::REG_OUTPUT_GAIN:  output_gain  <= cfg_data[mrb_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrb_ctrl
// Sequencer: decodes commands, walks the active modes, drains and finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  input  wire logic [mrb_pkg::FUNC_W-1:0]     func,
  input  wire logic [mrb_pkg::ACTIVE_W-1:0]   active_modes,
  input  wire mrb_pkg::stat_t                 stat,
  output logic                                req_ready,
  output mrb_pkg::cmd_t                       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                state, state_next;
  logic [mrb_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [mrb_pkg::CNT_W-1:0] num, num_next;
  logic [mrb_pkg::CNT_W-1:0] num_clamped;

  // mode count limited to the bank size
  always_comb begin
    if (int'(active_modes) > mrb_pkg::MAX_MODES) begin
      num_clamped = mrb_pkg::CNT_W'(mrb_pkg::MAX_MODES);
    end else begin
      num_clamped = mrb_pkg::CNT_W'(active_modes);
    end
  end

  assign req_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    num_next   = num;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (func)
            mrb_pkg::FUNC_LOAD: cmd.load = 1'b1;
            mrb_pkg::FUNC_RUN: begin
              cmd.start  = 1'b1;
              cnt_next   = '0;
              num_next   = num_clamped;
              state_next = S_RUN;
            end
            mrb_pkg::FUNC_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (cnt == num) begin
          state_next = S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          cmd.mode  = cnt[mrb_pkg::MODE_W-1:0];
          cnt_next  = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        if (stat.pipe_empty) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      num   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      num   <= num_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mrb_datapath.sv -----
// ----------------------------------------------------------------------------
// mrb_datapath
// Coefficient and delay memories, eight-stage mode pipeline, sum and output.
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mrb_pkg::cmd_t                      cmd,
  output mrb_pkg::stat_t                          stat,
  input  wire logic signed [mrb_pkg::COEF_W-1:0]  output_gain,
  input  wire logic        [mrb_pkg::IDX_W-1:0]   mode_index,
  input  wire logic signed [mrb_pkg::COEF_W-1:0]  coef_feedback_one,
  input  wire logic signed [mrb_pkg::COEF_W-1:0]  coef_feedback_two,
  input  wire logic signed [mrb_pkg::COEF_W-1:0]  coef_drive,
  input  wire logic signed [mrb_pkg::COEF_W-1:0]  coef_pickup,
  input  wire logic signed [mrb_pkg::SAMP_W-1:0]  force_sample,
  mrb_rsp_if.source                               rsp
);

  localparam int COEF_W = mrb_pkg::COEF_W;
  localparam int ST_W   = mrb_pkg::ST_W;
  localparam int SAMP_W = mrb_pkg::SAMP_W;
  localparam int ACC_W  = mrb_pkg::ACC_W;
  localparam int MODE_W = mrb_pkg::MODE_W;
  localparam int FRAC   = 30;
  localparam int LO_W   = 20;
  localparam int HI_W   = ST_W - LO_W;
  localparam int PH_W   = COEF_W + HI_W;
  localparam int PL_W   = COEF_W + LO_W + 1;
  localparam int RS_W   = COEF_W + ST_W + 1;
  localparam int Q_W    = RS_W - FRAC;
  localparam int PF_W   = COEF_W + SAMP_W;
  localparam int QF_W   = PF_W + 1 - FRAC;
  localparam int U_W    = Q_W + 2;

  // round(coef * val / 2^30) from the two partial products, half up
  function automatic logic signed [Q_W-1:0] qround(input logic signed [PH_W-1:0] ph,
                                                   input logic signed [PL_W-1:0] pl);
    logic [RS_W-1:0] s;
    s = ({{(RS_W-PH_W){ph[PH_W-1]}}, ph} << LO_W)
      + {{(RS_W-PL_W){pl[PL_W-1]}}, pl}
      + (RS_W'(1) << (FRAC - 1));
    return s[RS_W-1:FRAC];
  endfunction

  // same rounding for the single force product
  function automatic logic signed [QF_W-1:0] qround_f(input logic signed [PF_W-1:0] pf);
    logic [PF_W:0] s;
    s = {pf[PF_W-1], pf} + ((PF_W+1)'(1) << (FRAC - 1));
    return s[PF_W:FRAC];
  endfunction

  // clamp to the 40-bit state range, flag in the top bit
  function automatic logic [ST_W:0] sat_st(input logic signed [U_W-1:0] x);
    logic fits;
    fits = (&x[U_W-1:ST_W-1]) || !(|x[U_W-1:ST_W-1]);
    if (fits) return {1'b0, x[ST_W-1:0]};
    if (x[U_W-1]) return {1'b1, 1'b1, {(ST_W-1){1'b0}}};
    return {1'b1, 1'b0, {(ST_W-1){1'b1}}};
  endfunction

  // coefficient and delay memories
  logic signed [COEF_W-1:0] mem_a1 [mrb_pkg::MAX_MODES];
  logic signed [COEF_W-1:0] mem_a2 [mrb_pkg::MAX_MODES];
  logic signed [COEF_W-1:0] mem_b  [mrb_pkg::MAX_MODES];
  logic signed [COEF_W-1:0] mem_w  [mrb_pkg::MAX_MODES];
  logic signed [ST_W-1:0]   dly1   [mrb_pkg::MAX_MODES];
  logic signed [ST_W-1:0]   dly2   [mrb_pkg::MAX_MODES];
  logic [mrb_pkg::MAX_MODES-1:0] dly_ok;

  // stage 1: memory read data
  logic                     v1;
  logic [MODE_W-1:0]        m1;
  logic signed [COEF_W-1:0] rd_a1, rd_a2, rd_b, rd_w;
  logic signed [ST_W-1:0]   rd_y1, rd_y2;
  logic                     rd_ok;
  logic signed [ST_W-1:0]   y1_s1, y2_s1;

  // stage 2: feedback and drive partial products
  logic                     v2;
  logic [MODE_W-1:0]        m2;
  logic signed [PH_W-1:0]   p_a1h, p_a2h;
  logic signed [PL_W-1:0]   p_a1l, p_a2l;
  logic signed [PF_W-1:0]   p_b;
  logic signed [COEF_W-1:0] w2;
  logic signed [ST_W-1:0]   y1_2;

  // stage 3: rounded terms
  logic                     v3;
  logic [MODE_W-1:0]        m3;
  logic signed [Q_W-1:0]    q1_3, q2_3;
  logic signed [QF_W-1:0]   qb_3;
  logic signed [COEF_W-1:0] w3;
  logic signed [ST_W-1:0]   y1_3;
  logic signed [U_W-1:0]    u_sum;
  logic [ST_W:0]            u_sat;

  // stages 4..8: pickup, gain, sum
  logic                     v4, v5, v6, v7, v8;
  logic signed [ST_W-1:0]   u4, p6, q8;
  logic signed [COEF_W-1:0] w4;
  logic signed [PH_W-1:0]   p_wh, p_gh;
  logic signed [PL_W-1:0]   p_wl, p_gl;
  logic signed [Q_W-1:0]    p_wr, q_gr;
  logic [ST_W:0]            p_sat, q_sat;

  logic signed [SAMP_W-1:0] force_r;
  logic signed [ACC_W-1:0]  acc;
  logic                     sticky;
  logic                     acc_fits;
  logic signed [SAMP_W-1:0] acc_sat;

  // coefficient writes and reads
  always_ff @(posedge clk) begin
    if (cmd.load && (int'(mode_index) < mrb_pkg::MAX_MODES)) begin
      mem_a1[MODE_W'(mode_index)] <= coef_feedback_one;
      mem_a2[MODE_W'(mode_index)] <= coef_feedback_two;
      mem_b[MODE_W'(mode_index)]  <= coef_drive;
      mem_w[MODE_W'(mode_index)]  <= coef_pickup;
    end
    if (cmd.issue) begin
      rd_a1 <= mem_a1[cmd.mode];
      rd_a2 <= mem_a2[cmd.mode];
      rd_b  <= mem_b[cmd.mode];
      rd_w  <= mem_w[cmd.mode];
    end
  end

  // delay state: write back at stage 3, read at issue
  always_ff @(posedge clk) begin
    if (v3) begin
      dly1[m3] <= u_sat[ST_W-1:0];
      dly2[m3] <= y1_3;
    end
    if (cmd.issue) begin
      rd_y1 <= dly1[cmd.mode];
      rd_y2 <= dly2[cmd.mode];
      rd_ok <= dly_ok[cmd.mode];
    end
  end

  // per-entry valid bits stand for the all-zero reset and clear
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      dly_ok <= '0;
    end else if (v3) begin
      dly_ok[m3] <= 1'b1;
    end
  end

  assign y1_s1 = rd_ok ? rd_y1 : '0;
  assign y2_s1 = rd_ok ? rd_y2 : '0;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
    end else begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= {cmd.issue, v1, v2, v3, v4, v5, v6, v7};
    end
  end

  // stage 1 -> 2: partial products
  always_ff @(posedge clk) begin
    m1    <= cmd.mode;
    m2    <= m1;
    p_a1h <= rd_a1 * $signed(y1_s1[ST_W-1:LO_W]);
    p_a1l <= rd_a1 * $signed({1'b0, y1_s1[LO_W-1:0]});
    p_a2h <= rd_a2 * $signed(y2_s1[ST_W-1:LO_W]);
    p_a2l <= rd_a2 * $signed({1'b0, y2_s1[LO_W-1:0]});
    p_b   <= rd_b * force_r;
    w2    <= rd_w;
    y1_2  <= y1_s1;
  end

  // stage 2 -> 3: rounding
  always_ff @(posedge clk) begin
    m3   <= m2;
    q1_3 <= qround(p_a1h, p_a1l);
    q2_3 <= qround(p_a2h, p_a2l);
    qb_3 <= qround_f(p_b);
    w3   <= w2;
    y1_3 <= y1_2;
  end

  // stage 3: new state value
  assign u_sum = {{2{q1_3[Q_W-1]}}, q1_3} + {{2{q2_3[Q_W-1]}}, q2_3}
               + {{(U_W-QF_W){qb_3[QF_W-1]}}, qb_3};
  assign u_sat = sat_st(u_sum);

  // stages 3 -> 8
  always_ff @(posedge clk) begin
    u4   <= u_sat[ST_W-1:0];
    w4   <= w3;
    p_wh <= w4 * $signed(u4[ST_W-1:LO_W]);
    p_wl <= w4 * $signed({1'b0, u4[LO_W-1:0]});
    p6   <= p_sat[ST_W-1:0];
    p_gh <= output_gain * $signed(p6[ST_W-1:LO_W]);
    p_gl <= output_gain * $signed({1'b0, p6[LO_W-1:0]});
    q8   <= q_sat[ST_W-1:0];
  end

  // rounded pickup and gain terms, extended from their own sign
  assign p_wr  = qround(p_wh, p_wl);
  assign q_gr  = qround(p_gh, p_gl);
  assign p_sat = sat_st({{2{p_wr[Q_W-1]}}, p_wr});
  assign q_sat = sat_st({{2{q_gr[Q_W-1]}}, q_gr});

  // sum of contributions and saturation flag
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc     <= '0;
      sticky  <= 1'b0;
      force_r <= force_sample;
    end else begin
      if (v8) acc <= acc + {{(ACC_W-ST_W){q8[ST_W-1]}}, q8};
      sticky <= sticky | (v3 & u_sat[ST_W]) | (v5 & p_sat[ST_W]) | (v7 & q_sat[ST_W]);
    end
  end

  // clamp the sum to the output range
  assign acc_fits = (&acc[ACC_W-1:SAMP_W-1]) || !(|acc[ACC_W-1:SAMP_W-1]);
  always_comb begin
    if (acc_fits) begin
      acc_sat = acc[SAMP_W-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_sat = {1'b1, {(SAMP_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(SAMP_W-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.out_sample <= acc_sat;
      rsp.saturated  <= sticky | !acc_fits;
    end
  end

  assign stat.pipe_empty = !(v1 | v2 | v3 | v4 | v5 | v6 | v7 | v8);
  assign stat.out_free   = !rsp.valid || rsp.ready;

endmodule

`default_nettype wire

// ----- rtl/modal_resonator_bank.sv -----
// Modal resonator bank.
// Channels: req carries one command per transfer (valid/ready). func selects
// a coefficient load for mode_index, a force sample to process, or a clear
// of every delay state. rsp carries one output sample per processed force
// sample; loads and clears produce no transfer on rsp.
// Configuration: cfg_we writes cfg_data into register cfg_index (0: active
// mode count, 1: output gain, Q2.30). Write only while the bank is idle.
// Sequence: loads and clears leave the bank idle. A force sample streams
// the active modes one per cycle through an eight-stage multiply pipeline,
// then drains; the sum moves into the output register once that is free,
// and req.ready rises together with the result. The output register holds
// a finished sample; a new command is taken while it waits. If rsp stalls,
// the next sample's result is held in the sum register until the output
// register frees up, and req.ready stays low. Reset: delay states read as
// zero, active modes 0, gain 1.0; coefficient memories are not cleared and
// must be loaded before use.
// ----------------------------------------------------------------------------
// modal_resonator_bank
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module modal_resonator_bank (
  input  wire logic                             clk,
  input  wire logic                             rst,
  mrb_req_if.sink                               req,
  mrb_rsp_if.source                             rsp,
  input  wire logic                             cfg_we,
  input  wire logic [mrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mrb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [mrb_pkg::ACTIVE_W-1:0]      active_modes;
  logic signed [mrb_pkg::COEF_W-1:0] output_gain;
  mrb_pkg::cmd_t                     cmd;
  mrb_pkg::stat_t                    stat;

  // configuration
  mrb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .active_modes (active_modes),
    .output_gain  (output_gain)
  );

  // sequencer
  mrb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .func         (req.func),
    .active_modes (active_modes),
    .stat         (stat),
    .req_ready    (req.ready),
    .cmd          (cmd)
  );

  // datapath
  mrb_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .output_gain       (output_gain),
    .mode_index        (req.mode_index),
    .coef_feedback_one (req.coef_feedback_one),
    .coef_feedback_two (req.coef_feedback_two),
    .coef_drive        (req.coef_drive),
    .coef_pickup       (req.coef_pickup),
    .force_sample      (req.force_sample),
    .rsp               (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/mrb_checker.sv -----
// ----------------------------------------------------------------------------
// mrb_checker
// Port-level checks on the resonator bank, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mrb_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic [mrb_pkg::FUNC_W-1:0]    req_func,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [mrb_pkg::SAMP_W-1:0]    out_sample,
  input wire logic                          saturated
);

  // a stalled result holds its value
  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(out_sample) && $stable(saturated))

  // a force sample keeps the bank busy in the next cycle
  `ASSERT_NXT(a_run_busy, clk, rst, req_valid && req_ready && (req_func == mrb_pkg::FUNC_RUN), !req_ready)

  // no result shows up right after a transfer in
  `ASSERT_NXT(a_no_early_result, clk, rst, req_valid && req_ready && !rsp_valid, !rsp_valid)

  // results only appear when the bank was busy
  `ASSERT_IMP(a_result_from_busy, clk, rst, $rose(rsp_valid), !$past(req_ready))

endmodule

bind modal_resonator_bank mrb_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_func   (req.func),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .out_sample (rsp.out_sample),
  .saturated  (rsp.saturated)
);

`default_nettype wire
